// ===== rtl/wsts_pkg.sv =====
// Package for the weighted-score target selector: table depth, widths, function codes
// and score weights. No dependencies.
package wsts_pkg;

	localparam int MaxSensors = 64;
	localparam int IdxW = $clog2(MaxSensors);
	localparam int CntW = $clog2(MaxSensors + 1);

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_BEACON = 2'd1;
	localparam logic [1:0] FUNC_SELECT = 2'd2;

	localparam logic [1:0] REG_COUNT = 2'd0;
	localparam logic [1:0] REG_STALE = 2'd1;
	localparam logic [1:0] REG_MAXD  = 2'd2;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [16:0] W_ENERGY = 17'd36045;
	localparam logic [16:0] W_DEGREE = 17'd22938;
	localparam logic [16:0] W_DIST   = 17'd16384;

	// Degree term min(65536, floor(deg*65536/20)) for every six-bit degree. The fifth of
	// four times the degree comes from a reciprocal multiplication that is exact below 20.
	function automatic logic [16:0] degree_term(input logic [5:0] deg);
		logic [15:0] r;
		begin
			r = 16'(deg) * 16'd820;
			if (deg >= 6'd20) begin
				degree_term = ONE_Q16;
			end else begin
				degree_term = 17'(deg) * 17'd3276 + 17'(r[15:10]);
			end
		end
	endfunction

endpackage

// ===== rtl/wsts_arith.sv =====
// Iterative arithmetic unit of the selector: bit-serial integer square root followed by a
// restoring divide of d*65536 by the normaliser. Depends on wsts_pkg.
module wsts_arith (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [48:0] radicand,
	input  logic [23:0] divisor,
	output logic        done,
	output logic [16:0] dist_term
);

	typedef enum logic [1:0] {A_IDLE, A_SQRT, A_CMP, A_DIV} astate_t;

	astate_t     state_q;
	logic [49:0] rad_q;
	logic [25:0] rem_q;
	logic [24:0] root_q;
	logic [4:0]  cnt_q;
	logic [23:0] dvs_q;
	logic [23:0] drem_q;
	logic [15:0] quo_q;
	logic [16:0] dist_q;

	logic [27:0] part;
	logic [27:0] trial;
	logic [24:0] dr_sh;
	logic        qbit;
	logic [15:0] quo_nx;

	always_comb begin
		part   = {rem_q, rad_q[49:48]};
		trial  = {1'b0, root_q, 2'b01};
		dr_sh  = {drem_q, 1'b0};
		qbit   = (dr_sh >= {1'b0, dvs_q});
		quo_nx = {quo_q[14:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
			rad_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			dvs_q   <= 24'd1;
			drem_q  <= '0;
			quo_q   <= '0;
			dist_q  <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (start) begin
						rad_q   <= {1'b0, radicand};
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= 5'd25;
						dvs_q   <= (divisor == 24'd0) ? 24'd1 : divisor;
						state_q <= A_SQRT;
					end
				end
				A_SQRT: begin
					if (part >= trial) begin
						rem_q  <= 26'(part - trial);
						root_q <= {root_q[23:0], 1'b1};
					end else begin
						rem_q  <= part[25:0];
						root_q <= {root_q[23:0], 1'b0};
					end
					rad_q <= {rad_q[47:0], 2'b00};
					if (cnt_q == 5'd1) begin
						state_q <= A_CMP;
					end
					cnt_q <= cnt_q - 5'd1;
				end
				A_CMP: begin
					// A distance at or beyond the normaliser saturates the term at one.
					if (root_q >= {1'b0, dvs_q}) begin
						dist_q  <= wsts_pkg::ONE_Q16;
						done    <= 1'b1;
						state_q <= A_IDLE;
					end else begin
						drem_q  <= root_q[23:0];
						quo_q   <= '0;
						cnt_q   <= 5'd16;
						state_q <= A_DIV;
					end
				end
				A_DIV: begin
					drem_q <= qbit ? 24'(dr_sh - {1'b0, dvs_q}) : dr_sh[23:0];
					quo_q  <= quo_nx;
					if (cnt_q == 5'd1) begin
						dist_q  <= {1'b0, quo_nx};
						done    <= 1'b1;
						state_q <= A_IDLE;
					end
					cnt_q <= cnt_q - 5'd1;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign dist_term = dist_q;

endmodule

// ===== rtl/weighted_score_target_selector_top.sv =====
// Top level of the weighted-score target selector: sensor table, select sequencer and
// result register. Depends on wsts_pkg and wsts_arith.
//
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | func, sensor_index, pos_x/y, flags, energy, degree, now
// out     | out_valid / out_ready| found, best_index, best_score
// cfg     | cfg_we               | cfg_index, cfg_data
//
// Load, beacon and unused items leave the sequencer idle. Select reads the entries in turn:
// it skips an unknown or stale entry and scores an eligible one through the 25-step square
// root and, unless the entry lies at or beyond the normalising distance, the 16-step divide
// of the arithmetic unit. Reset clears the table's known flags and sets the sequencer,
// configuration and result registers to their reset values at once. The block takes no
// item while a select runs or its result waits for a transfer.
module weighted_score_target_selector_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [5:0]  sensor_index,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic        x_present,
	input  logic        y_present,
	input  logic signed [17:0] energy,
	input  logic        energy_present,
	input  logic [5:0]  degree,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [5:0]  best_index,
	output logic [16:0] best_score
);

	localparam int IW = wsts_pkg::IdxW;
	localparam int CW = wsts_pkg::CntW;

	typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_WAIT, S_SCORE, S_NEXT, S_OUT}
		state_t;

	state_t          state_q;
	logic [6:0]      count_q;
	logic [31:0]     stale_q;
	logic [23:0]     maxd_q;
	logic [wsts_pkg::MaxSensors-1:0] known_q;

	logic signed [23:0] mem_x [wsts_pkg::MaxSensors];
	logic signed [23:0] mem_y [wsts_pkg::MaxSensors];
	logic [16:0]        mem_e [wsts_pkg::MaxSensors];
	logic [5:0]         mem_d [wsts_pkg::MaxSensors];
	logic [31:0]        mem_t [wsts_pkg::MaxSensors];

	logic [CW-1:0]   idx_q;
	logic signed [23:0] ux_q, uy_q;
	logic [31:0]     now_q;
	logic signed [23:0] rx_q, ry_q;
	logic [16:0]     re_q;
	logic [5:0]      rd_q;
	logic [31:0]     rt_q;
	logic            rk_q;
	logic [48:0]     rad_q;
	logic            astart_q;
	logic            adone;
	logic [16:0]     dterm;
	logic            found_q;
	logic [IW-1:0]   bidx_q;
	logic [16:0]     bscore_q;
	logic [16:0]     edterm_q;
	logic [35:0]     acc_q;
	logic [1:0]      sub_q;

	logic [CW-1:0]   n_act;
	logic [24:0]     mul_a;
	logic [49:0]     mul_p;
	logic signed [24:0] dx, dy;
	logic [24:0]     adx, ady;
	logic [16:0]     clamped_e;

	assign n_act = (count_q > 7'(wsts_pkg::MaxSensors)) ? CW'(wsts_pkg::MaxSensors)
	                                                  : CW'(count_q);
	assign dx  = 25'(rx_q) - 25'(ux_q);
	assign dy  = 25'(ry_q) - 25'(uy_q);
	assign adx = dx[24] ? 25'(-dx) : dx;
	assign ady = dy[24] ? 25'(-dy) : dy;
	assign mul_a = (sub_q == 2'd0) ? adx : ady;
	assign mul_p = 50'(mul_a) * 50'(mul_a);
	assign clamped_e = energy[17] ? 17'd0 :
	                   (energy > 18'sd65536) ? wsts_pkg::ONE_Q16 : energy[16:0];

	wsts_arith u_arith (
		.clk(clk), .arst_n(arst_n), .start(astart_q), .radicand(rad_q),
		.divisor(maxd_q), .done(adone), .dist_term(dterm)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign found      = found_q;
	assign best_index = found_q ? bidx_q : '0;
	assign best_score = found_q ? bscore_q : '0;

	// A beacon to an entry that was never written leaves its absent fields at zero.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready && (func == wsts_pkg::FUNC_LOAD ||
		    func == wsts_pkg::FUNC_BEACON) && CW'(sensor_index) < n_act) begin
			if (func == wsts_pkg::FUNC_LOAD) begin
				mem_x[sensor_index] <= pos_x;
				mem_y[sensor_index] <= pos_y;
				mem_e[sensor_index] <= wsts_pkg::ONE_Q16;
				mem_d[sensor_index] <= degree;
				mem_t[sensor_index] <= '0;
			end else begin
				if (x_present) mem_x[sensor_index] <= pos_x;
				else if (!known_q[sensor_index]) mem_x[sensor_index] <= '0;
				if (y_present) mem_y[sensor_index] <= pos_y;
				else if (!known_q[sensor_index]) mem_y[sensor_index] <= '0;
				if (energy_present) mem_e[sensor_index] <= clamped_e;
				else if (!known_q[sensor_index]) mem_e[sensor_index] <= '0;
				if (!known_q[sensor_index]) mem_d[sensor_index] <= '0;
				mem_t[sensor_index] <= now;
			end
		end
		rx_q <= mem_x[idx_q[IW-1:0]];
		ry_q <= mem_y[idx_q[IW-1:0]];
		re_q <= mem_e[idx_q[IW-1:0]];
		rd_q <= mem_d[idx_q[IW-1:0]];
		rt_q <= mem_t[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			stale_q  <= 32'd3000;
			maxd_q   <= 24'd16000;
			known_q  <= '0;
			astart_q <= 1'b0;
			found_q  <= 1'b0;
			idx_q    <= '0;
			sub_q    <= '0;
			rk_q     <= 1'b0;
			ux_q     <= '0;
			uy_q     <= '0;
			now_q    <= '0;
			bidx_q   <= '0;
			bscore_q <= '0;
			rad_q    <= '0;
			edterm_q <= '0;
			acc_q    <= '0;
		end else begin
			astart_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					wsts_pkg::REG_COUNT: count_q <= cfg_data[6:0];
					wsts_pkg::REG_STALE: stale_q <= cfg_data;
					wsts_pkg::REG_MAXD:  maxd_q  <= cfg_data[23:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if ((func == wsts_pkg::FUNC_LOAD || func == wsts_pkg::FUNC_BEACON)
						    && CW'(sensor_index) < n_act) begin
							known_q[sensor_index] <= 1'b1;
						end
						if (func == wsts_pkg::FUNC_SELECT) begin
							ux_q    <= pos_x;
							uy_q    <= pos_y;
							now_q   <= now;
							idx_q   <= '0;
							found_q <= 1'b0;
							bidx_q  <= '0;
							bscore_q <= '0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (idx_q >= n_act) begin
						state_q <= S_OUT;
					end else begin
						rk_q    <= known_q[idx_q[IW-1:0]];
						sub_q   <= 2'd0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (!rk_q || (rt_q != 32'd0 && (now_q - rt_q) > stale_q)) begin
						state_q <= S_NEXT;
					end else if (sub_q == 2'd0) begin
						rad_q <= 49'(mul_p);
						sub_q <= 2'd1;
					end else begin
						rad_q    <= rad_q + 49'(mul_p);
						astart_q <= 1'b1;
						edterm_q <= wsts_pkg::degree_term(rd_q);
						acc_q    <= 36'(re_q) * 36'(wsts_pkg::W_ENERGY);
						state_q  <= S_WAIT;
					end
				end
				S_WAIT: begin
					acc_q <= (sub_q == 2'd1) ? acc_q + 36'(edterm_q) * 36'(wsts_pkg::W_DEGREE)
					                         : acc_q;
					sub_q <= 2'd2;
					if (adone) begin
						state_q <= S_SCORE;
					end
				end
				S_SCORE: begin
					begin : sc
						logic [35:0] s;
						s = acc_q + 36'(wsts_pkg::ONE_Q16 - dterm) * 36'(wsts_pkg::W_DIST)
						    + 36'd32768;
						if (!found_q || s[32:16] > bscore_q) begin
							found_q  <= 1'b1;
							bscore_q <= s[32:16];
							bidx_q   <= idx_q[IW-1:0];
						end
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_READ;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input ready while result pending");
	a_score_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_score <= 17'd75367) else $error("score out of range");
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (best_score == 17'd0 && best_index == 6'd0))
		else $error("empty result not zero");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for weighted_score_target_selector_top: a scoring predictor
// tracks the sensor table and checks every select result. Depends on wsts_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = wsts_pkg::REG_COUNT;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = wsts_pkg::FUNC_LOAD;
	logic [5:0] sensor_index = '0;
	logic signed [23:0] pos_x = '0;
	logic signed [23:0] pos_y = '0;
	logic x_present = 1'b0;
	logic y_present = 1'b0;
	logic signed [17:0] energy = '0;
	logic energy_present = 1'b0;
	logic [5:0] degree = '0;
	logic [31:0] now = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic [5:0] best_index;
	logic [16:0] best_score;

	localparam logic [1:0] FUNC_NOP = 2'd3;

	typedef struct packed {
		logic        found;
		logic [5:0]  index;
		logic [16:0] score;
	} pick_t;

	pick_t pick_buf[16];
	int pick_wr = 0;
	int pick_rd = 0;
	int errors = 0;
	longint cycles = 0;

	logic        tab_known[wsts_pkg::MaxSensors];
	logic [23:0] tab_x[wsts_pkg::MaxSensors];
	logic [23:0] tab_y[wsts_pkg::MaxSensors];
	logic [16:0] tab_energy[wsts_pkg::MaxSensors];
	logic [5:0]  tab_degree[wsts_pkg::MaxSensors];
	logic [31:0] tab_seen[wsts_pkg::MaxSensors];
	logic [6:0]  in_use = 7'd0;
	logic [31:0] stale_lim = 32'd3000;
	logic [23:0] max_dist = 24'd16000;

	weighted_score_target_selector_top u_dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd8000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic pick_t best_target(input logic [23:0] ux, input logic [23:0] uy,
			input logic [31:0] t);
		pick_t p;
		longint unsigned md, dx2, dy2, d, dn, dg, s, bs;
		longint sx, sy;
		int n;
		p = '0;
		bs = 0;
		md = (max_dist == 0) ? 1 : max_dist;
		n = (in_use > wsts_pkg::MaxSensors) ? wsts_pkg::MaxSensors : in_use;
		for (int i = 0; i < n; i++) begin
			if (!tab_known[i]) continue;
			if (tab_seen[i] != 0 && 32'(t - tab_seen[i]) > stale_lim) continue;
			sx = longint'($signed(tab_x[i])) - longint'($signed(ux));
			sy = longint'($signed(tab_y[i])) - longint'($signed(uy));
			dx2 = sx * sx;
			dy2 = sy * sy;
			d = int_sqrt(dx2 + dy2);
			dn = (d * 65536) / md;
			if (dn > 65536) dn = 65536;
			dg = (longint'(tab_degree[i]) * 65536) / 20;
			if (dg > 65536) dg = 65536;
			s = (36045 * longint'(tab_energy[i]) + 22938 * dg + 16384 * (65536 - dn) + 32768)
				>> 16;
			if (!p.found || s > bs) begin
				p.found = 1'b1;
				bs = s;
				p.index = 6'(i);
				p.score = 17'(s);
			end
		end
		return p;
	endfunction

	function automatic void update_table(input logic [1:0] f, input logic [5:0] idx,
			input logic [23:0] x, input logic [23:0] y, input logic xp, input logic yp,
			input logic signed [17:0] e, input logic ep, input logic [5:0] dg,
			input logic [31:0] t);
		int n;
		n = (in_use > wsts_pkg::MaxSensors) ? wsts_pkg::MaxSensors : in_use;
		if (f == wsts_pkg::FUNC_SELECT) begin
			pick_buf[pick_wr % 16] = best_target(x, y, t);
			pick_wr++;
		end else if ((f == wsts_pkg::FUNC_LOAD || f == wsts_pkg::FUNC_BEACON) && idx < n) begin
			tab_known[idx] = 1'b1;
			if (f == wsts_pkg::FUNC_LOAD) begin
				tab_x[idx] = x;
				tab_y[idx] = y;
				tab_energy[idx] = wsts_pkg::ONE_Q16;
				tab_degree[idx] = dg;
				tab_seen[idx] = '0;
			end else begin
				if (xp) tab_x[idx] = x;
				if (yp) tab_y[idx] = y;
				if (ep) tab_energy[idx] = (e < 0) ? 17'd0 :
					((e > 65536) ? wsts_pkg::ONE_Q16 : 17'(e));
				tab_seen[idx] = t;
			end
		end
	endfunction

	function automatic int gap_len();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) g = 0;
		return g;
	endfunction

	task automatic send_item(input logic [1:0] f, input logic [5:0] idx,
			input logic [23:0] x, input logic [23:0] y, input logic xp, input logic yp,
			input logic [17:0] e, input logic ep, input logic [5:0] dg, input logic [31:0] t);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		func <= f; sensor_index <= idx; pos_x <= x; pos_y <= y;
		x_present <= xp; y_present <= yp; energy <= e; energy_present <= ep;
		degree <= dg; now <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		update_table(f, idx, x, y, xp, yp, e, ep, dg, t);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] r, input logic [31:0] v);
		in_valid <= 1'b0;
		while (pick_wr != pick_rd) @(negedge clk);
		repeat (5000) @(negedge clk);
		cfg_we <= 1'b1; cfg_index <= r; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (r)
			wsts_pkg::REG_COUNT: in_use = v[6:0];
			wsts_pkg::REG_STALE: stale_lim = v;
			wsts_pkg::REG_MAXD:  max_dist = v[23:0];
			default: ;
		endcase
	endtask

	// Result side: random stalls and an in-order comparison against the predicted picks.
	always @(negedge clk) begin
		if ($urandom_range(0, 9) == 0) out_ready <= 1'b0;
		else if ($urandom_range(0, 2) != 0) out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		pick_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pick_wr == pick_rd) begin
				$error("result transfer with no select outstanding");
				errors++;
			end else begin
				e = pick_buf[pick_rd % 16];
				pick_rd++;
				if (found !== e.found) begin
					$error("found: expected %0d, actual %0d", e.found, found);
					errors++;
				end
				if (best_index !== e.index) begin
					$error("best_index: expected %0d, actual %0d", e.index, best_index);
					errors++;
				end
				if (best_score !== e.score) begin
					$error("best_score: expected %0d, actual %0d", e.score, best_score);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		write_reg(wsts_pkg::REG_COUNT, 32'd64);
		send_item(wsts_pkg::FUNC_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(wsts_pkg::FUNC_LOAD, 0, 24'h7FFFFF, 24'h800000, 1, 1, 18'h1FFFF, 1, 6'd63,
			32'hFFFFFFFF);
		send_item(wsts_pkg::FUNC_LOAD, 63, 24'h800000, 24'h7FFFFF, 0, 0, 18'h20000, 0, 6'd0, 0);
		send_item(wsts_pkg::FUNC_LOAD, 5, 100, -24'sd100, 0, 0, 0, 0, 6'd20, 0);
		send_item(wsts_pkg::FUNC_LOAD, 6, 100, -24'sd100, 0, 0, 0, 0, 6'd20, 0);
		send_item(wsts_pkg::FUNC_SELECT, 0, 100, -24'sd100, 0, 0, 0, 0, 0, 5);
		send_item(wsts_pkg::FUNC_BEACON, 5, 0, 0, 0, 0, 18'h20000, 1, 0, 1000);
		send_item(wsts_pkg::FUNC_BEACON, 6, 400, 400, 1, 1, 18'h1FFFF, 1, 0, 1000);
		send_item(wsts_pkg::FUNC_BEACON, 0, 9, 9, 1, 0, 18'd30000, 1, 0, 32'hFFFFFFF0);
		send_item(wsts_pkg::FUNC_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 4000);
		send_item(wsts_pkg::FUNC_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 4001);
		send_item(wsts_pkg::FUNC_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 500);
		send_item(FUNC_NOP, 7, 1, 1, 1, 1, 1, 1, 1, 1);
		send_item(wsts_pkg::FUNC_SELECT, 0, 24'h800000, 24'h800000, 0, 0, 0, 0, 0,
			32'hFFFFFFFF);
		write_reg(wsts_pkg::REG_MAXD, 32'd0);
		send_item(wsts_pkg::FUNC_SELECT, 0, 3, 4, 0, 0, 0, 0, 0, 1000);
		write_reg(wsts_pkg::REG_MAXD, 32'hFFFFFF);
		write_reg(wsts_pkg::REG_STALE, 32'hFFFFFFFF);
		send_item(wsts_pkg::FUNC_SELECT, 0, 24'h7FFFFF, 0, 0, 0, 0, 0, 0, 0);
		write_reg(wsts_pkg::REG_STALE, 32'd0);
		send_item(wsts_pkg::FUNC_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 1000);
		write_reg(wsts_pkg::REG_COUNT, 32'd127);
		send_item(wsts_pkg::FUNC_BEACON, 63, 0, 0, 0, 0, 0, 0, 0, 7);
		write_reg(wsts_pkg::REG_COUNT, 32'd6);
		send_item(wsts_pkg::FUNC_LOAD, 6, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(wsts_pkg::FUNC_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 1000);
	endtask

	task automatic test_random(input int items);
		logic [31:0] t;
		logic [1:0] f;
		int k;
		t = $urandom_range(1, 100);
		for (int i = 0; i < items; i++) begin
			if (i % 60 == 0) begin
				write_reg(wsts_pkg::REG_COUNT, (i % 120 == 0) ? $urandom_range(0, 127) :
					$urandom_range(1, 12));
				write_reg(wsts_pkg::REG_STALE,
					$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400));
				write_reg(wsts_pkg::REG_MAXD,
					$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000));
			end
			k = $urandom_range(0, 19);
			f = (k < 7) ? wsts_pkg::FUNC_LOAD : (k < 13) ? wsts_pkg::FUNC_BEACON :
				(k < 19) ? wsts_pkg::FUNC_SELECT : FUNC_NOP;
			t = ($urandom_range(0, 19) == 0) ? $urandom : t + $urandom_range(0, 120);
			send_item(f, 6'(($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 12)),
				24'(($urandom_range(0, 3) == 0) ? $urandom :
					32'($signed($urandom_range(0, 4000)) - 2000)),
				24'(($urandom_range(0, 3) == 0) ? $urandom :
					32'($signed($urandom_range(0, 4000)) - 2000)),
				1'($urandom), 1'($urandom), 18'($urandom), 1'($urandom), 6'($urandom), t);
		end
	endtask

	initial begin
		for (int i = 0; i < wsts_pkg::MaxSensors; i++) begin
			tab_known[i] = 0; tab_x[i] = 0; tab_y[i] = 0;
			tab_energy[i] = 0; tab_degree[i] = 0; tab_seen[i] = 0;
		end
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(290);
		in_valid <= 1'b0;
		while (pick_wr != pick_rd) @(negedge clk);
		repeat (6000) @(negedge clk);
		if (errors == 0 && pick_wr == pick_rd) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/wsts_pkg.sv
rtl/wsts_arith.sv
rtl/weighted_score_target_selector_top.sv
test/tb.sv
